[src/ita_pkg.sv]
// Shared constants, types and helpers for the integer-to-ASCII formatter.
package ita_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int MAX_DIGITS  = 23;
	localparam int DIG_W       = 4;
	localparam int CNT_W       = 5;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);

	localparam logic [2:0] ACT_SDEC = 3'd0;
	localparam logic [2:0] ACT_UDEC = 3'd1;
	localparam logic [2:0] ACT_OCT  = 3'd2;
	localparam logic [2:0] ACT_LHEX = 3'd3;
	localparam logic [2:0] ACT_UHEX = 3'd4;

	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	typedef logic [DIG_W-1:0] digit_t;

	typedef struct packed {
		logic load;
		logic bit_step;
		logic dig_step;
	} conv_ctrl_t;

	typedef struct packed {
		digit_t top;
		digit_t next;
	} conv_stat_t;

	function automatic logic [7:0] digit_ascii(input digit_t d, input logic upper);
		logic [7:0] d8;
		begin
			d8 = {4'b0000, d};
			if (d < 4'd10) begin
				digit_ascii = 8'h30 + d8;
			end else begin
				digit_ascii = (upper ? 8'h41 : 8'h61) + d8 - 8'd10;
			end
		end
	endfunction

endpackage

[src/ita_conv.sv]
// Bit-serial radix converter: shift-and-adjust digit lanes plus a digit shift line.
module ita_conv (
	input  logic                            clk,
	input  ita_pkg::conv_ctrl_t             ctrl,
	input  logic [ita_pkg::VALUE_WIDTH-1:0] value,
	input  logic [1:0]                      base,
	output ita_pkg::conv_stat_t             stat
);
	import ita_pkg::*;

	logic [VALUE_WIDTH-1:0] val_q;
	logic [1:0]             base_q;
	digit_t                 dig_q [MAX_DIGITS];
	digit_t                 dig_nx [MAX_DIGITS];
	logic [MAX_DIGITS:0]    carry;

	always_comb begin
		digit_t adj;
		carry[0] = val_q[VALUE_WIDTH-1];
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj = dig_q[i];
			if (base_q == BASE_DEC && dig_q[i] >= 4'd5) begin
				adj = dig_q[i] + 4'd3;
			end
			if (base_q == BASE_OCT) begin
				dig_nx[i]  = {1'b0, adj[1:0], carry[i]};
				carry[i+1] = adj[2];
			end else begin
				dig_nx[i]  = {adj[2:0], carry[i]};
				carry[i+1] = adj[3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q  <= value;
			base_q <= base;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				dig_q[i] <= '0;
			end
		end else if (ctrl.bit_step) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
			for (int i = 0; i < MAX_DIGITS; i++) begin
				dig_q[i] <= dig_nx[i];
			end
		end else if (ctrl.dig_step) begin
			dig_q[0] <= '0;
			for (int i = 1; i < MAX_DIGITS; i++) begin
				dig_q[i] <= dig_q[i-1];
			end
		end
	end

	assign stat.top  = dig_q[MAX_DIGITS-1];
	assign stat.next = dig_q[MAX_DIGITS-2];

endmodule

[src/ita_pad.sv]
// Precision and field-width rules for zero padding and the zero-fill flag.
module ita_pad (
	input  logic signed [8:0]         prec,
	input  logic [7:0]                width_total,
	input  logic [1:0]                prefix_chars,
	input  logic [7:0]                pad_in,
	input  logic                      zero_fill_in,
	input  logic                      left_align,
	input  logic [ita_pkg::CNT_W-1:0] count,
	output logic [7:0]                pad_out,
	output logic                      zero_fill_out
);
	import ita_pkg::*;

	logic signed [9:0]  prec_x;
	logic signed [9:0]  cnt_x;
	logic [9:0]         prec_diff;
	logic signed [10:0] avail;

	assign prec_x    = {prec[8], prec};
	assign cnt_x     = signed'({{(10-CNT_W){1'b0}}, count});
	assign prec_diff = prec_x - cnt_x;
	assign avail     = signed'({3'b000, width_total}) - signed'({9'd0, prefix_chars})
	                 - signed'({3'b000, pad_in}) - signed'({{(11-CNT_W){1'b0}}, count});

	always_comb begin
		pad_out       = pad_in;
		zero_fill_out = zero_fill_in;
		if (prec_x > cnt_x) begin
			pad_out       = prec_diff[7:0];
			zero_fill_out = 1'b0;
		end else if (prec[8] && zero_fill_in && !left_align) begin
			if (!avail[10] && avail != 11'sd0) begin
				pad_out = avail[7:0];
			end
		end
	end

endmodule

[src/integer_to_ascii_formatter_top.sv]
// Top level of the integer-to-ASCII formatter: control sequencer and output register.
//
//   channel | handshake          | words
//   --------+--------------------+--------------------------------------------
//   in      | in_valid/in_ready  | one value with kind, precision, width, flags
//   out     | out_valid/out_ready| one digit (or one empty word) per word
//
// A value passes through an accept step, bit-serial conversion through the digit lanes,
// leading-zero removal on the digit shift line, a padding step and then output at one
// word per cycle while out_ready is high.
// in_ready is high only while no value is in flight. Output stalls hold the digit
// shift line. Reset clears the sequencer and the output valid.
module integer_to_ascii_formatter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [63:0]                     number,
	input  logic [2:0]                      action,
	input  logic signed [8:0]               min_digits,
	input  logic [7:0]                      width_total,
	input  logic [1:0]                      prefix_chars,
	input  logic [7:0]                      pad_in,
	input  logic                            alternate_form,
	input  logic                            zero_fill_in,
	input  logic                            left_align,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            has_digit,
	output logic [7:0]                      digit_char,
	output logic                            is_last,
	output logic [ita_pkg::CNT_W-1:0]       digit_count,
	output logic [7:0]                      pad_out,
	output logic                            zero_fill_out
);
	import ita_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_NORM = 3'd2;
	localparam logic [2:0] S_PAD  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]             state_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       rem_q;
	logic signed [8:0]      prec_q;
	logic [7:0]             width_q;
	logic [1:0]             prefix_q;
	logic [7:0]             pad_q;
	logic                   zf_q;
	logic                   left_q;
	logic                   upper_q;
	logic                   alt_oct_q;
	logic                   empty_q;
	logic                   out_valid_q;
	logic                   has_digit_q;
	logic [7:0]             char_q;
	logic                   last_q;
	logic [7:0]             pad_res_q;
	logic                   zf_res_q;

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	logic [1:0]             base;
	logic                   in_acc;
	logic                   out_acc;
	logic                   norm_stop;
	logic [7:0]             pad_calc;
	logic                   zf_calc;
	conv_ctrl_t             ctrl;
	conv_stat_t             stat;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid_q && out_ready;

	assign raw = number[VALUE_WIDTH-1:0];
	assign mag = (action == ACT_SDEC && raw[VALUE_WIDTH-1]) ? (~raw + 1'b1) : raw;

	always_comb begin
		unique case (action)
			ACT_OCT:            base = BASE_OCT;
			ACT_LHEX, ACT_UHEX: base = BASE_HEX;
			default:            base = BASE_DEC;
		endcase
	end

	assign norm_stop = empty_q || stat.top != '0 || cnt_q == CNT_W'(1)
	                || (alt_oct_q && stat.next != '0);

	always_comb begin
		ctrl          = '0;
		ctrl.load     = in_acc;
		ctrl.bit_step = (state_q == S_CONV);
		ctrl.dig_step = (state_q == S_NORM && !norm_stop) || (state_q == S_PAD)
		             || (state_q == S_EMIT && out_acc && !last_q);
	end

	ita_conv u_conv (
		.clk   (clk),
		.ctrl  (ctrl),
		.value (mag),
		.base  (base),
		.stat  (stat)
	);

	ita_pad u_pad (
		.prec          (prec_q),
		.width_total   (width_q),
		.prefix_chars  (prefix_q),
		.pad_in        (pad_q),
		.zero_fill_in  (zf_q),
		.left_align    (left_q),
		.count         (cnt_q),
		.pad_out       (pad_calc),
		.zero_fill_out (zf_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (bit_cnt_q == '0) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (norm_stop) begin
						state_q <= S_PAD;
					end
				end
				S_PAD: begin
					state_q     <= S_EMIT;
					out_valid_q <= 1'b1;
				end
				S_EMIT: begin
					if (out_acc && last_q) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			bit_cnt_q <= BIT_CNT_W'(VALUE_WIDTH - 1);
			cnt_q     <= CNT_W'(MAX_DIGITS);
			prec_q    <= min_digits;
			width_q   <= width_total;
			prefix_q  <= prefix_chars;
			pad_q     <= pad_in;
			zf_q      <= zero_fill_in;
			left_q    <= left_align;
			upper_q   <= (action == ACT_UHEX);
			alt_oct_q <= (action == ACT_OCT) && alternate_form;
			empty_q   <= (mag == '0) && (min_digits == 9'sd0)
			          && !((action == ACT_OCT) && alternate_form);
		end
		if (state_q == S_CONV) begin
			bit_cnt_q <= bit_cnt_q - 1'b1;
		end
		if (state_q == S_NORM) begin
			if (empty_q) begin
				cnt_q <= '0;
			end else if (!norm_stop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
		if (state_q == S_PAD) begin
			pad_res_q   <= pad_calc;
			zf_res_q    <= zf_calc;
			rem_q       <= cnt_q;
			has_digit_q <= (cnt_q != '0);
			char_q      <= (cnt_q != '0) ? digit_ascii(stat.top, upper_q) : 8'h00;
			last_q      <= (cnt_q <= CNT_W'(1));
		end
		if (state_q == S_EMIT && out_acc && !last_q) begin
			rem_q  <= rem_q - 1'b1;
			char_q <= digit_ascii(stat.top, upper_q);
			last_q <= (rem_q == CNT_W'(2));
		end
	end

	assign out_valid     = out_valid_q;
	assign has_digit     = has_digit_q;
	assign digit_char    = char_q;
	assign is_last       = last_q;
	assign digit_count   = cnt_q;
	assign pad_out       = pad_res_q;
	assign zero_fill_out = zf_res_q;

endmodule

[bench/tb.sv]
// Testbench for the integer-to-ASCII formatter: directed and random values checked digit by digit.
module tb;
	import ita_pkg::*;

	localparam logic [2:0] ACT_RSV5 = 3'd5;
	localparam logic [2:0] ACT_RSV6 = 3'd6;
	localparam logic [2:0] ACT_RSV7 = 3'd7;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_CYCLES = 150;
	localparam int RANDOM_PER_PHASE = 120;

	typedef struct {
		logic [63:0]       number;
		logic [2:0]        action;
		logic signed [8:0] min_digits;
		logic [7:0]        width_total;
		logic [1:0]        prefix_chars;
		logic [7:0]        pad_in;
		logic              alternate_form;
		logic              zero_fill_in;
		logic              left_align;
	} value_word_t;

	typedef struct {
		logic             has_digit;
		logic [7:0]       digit_char;
		logic             is_last;
		logic [CNT_W-1:0] digit_count;
		logic [7:0]       pad_out;
		logic             zero_fill_out;
	} digit_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [63:0] number = '0;
	logic [2:0] action = '0;
	logic signed [8:0] min_digits = '0;
	logic [7:0] width_total = '0;
	logic [1:0] prefix_chars = '0;
	logic [7:0] pad_in = '0;
	logic alternate_form = 1'b0;
	logic zero_fill_in = 1'b0;
	logic left_align = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic has_digit;
	logic [7:0] digit_char;
	logic is_last;
	logic [CNT_W-1:0] digit_count;
	logic [7:0] pad_out;
	logic zero_fill_out;

	value_word_t values_to_send[$];
	digit_word_t digit_words_due[$];
	value_word_t in_flight;
	value_word_t next_value;
	digit_word_t due;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int values_sent = 0;
	int words_checked = 0;
	int mismatch_count = 0;

	integer_to_ascii_formatter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.number(number),
		.action(action),
		.min_digits(min_digits),
		.width_total(width_total),
		.prefix_chars(prefix_chars),
		.pad_in(pad_in),
		.alternate_form(alternate_form),
		.zero_fill_in(zero_fill_in),
		.left_align(left_align),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.has_digit(has_digit),
		.digit_char(digit_char),
		.is_last(is_last),
		.digit_count(digit_count),
		.pad_out(pad_out),
		.zero_fill_out(zero_fill_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void predict_digits(input value_word_t w);
		logic [63:0] mag;
		logic [63:0] radix;
		logic [7:0] dig;
		logic [7:0] letter;
		logic [7:0] text[$];
		int prec;
		int pad;
		int avail;
		int count;
		logic zf;
		digit_word_t o;
		mag = w.number;
		case (w.action)
			ACT_OCT: radix = 64'd8;
			ACT_LHEX, ACT_UHEX: radix = 64'd16;
			default: radix = 64'd10;
		endcase
		letter = (w.action == ACT_UHEX) ? "A" : "a";
		if (w.action == ACT_SDEC && mag[63])
			mag = -mag;
		prec = w.min_digits;
		if (mag == 64'd0 && prec == 0) begin
			if (radix == 64'd8 && w.alternate_form)
				text.push_front("0");
		end else begin
			do begin
				dig = 8'(mag % radix);
				mag = mag / radix;
				text.push_front(dig < 8'd10 ? "0" + dig : letter + dig - 8'd10);
			end while (mag != 64'd0);
			if (radix == 64'd8 && w.alternate_form && text[0] != "0")
				text.push_front("0");
		end
		count = text.size();
		pad = w.pad_in;
		zf = w.zero_fill_in;
		if (prec > count) begin
			pad = prec - count;
			zf = 1'b0;
		end else if (prec < 0 && zf && !w.left_align) begin
			avail = w.width_total;
			avail = avail - int'(w.prefix_chars) - int'(w.pad_in) - count;
			if (avail > 0)
				pad = avail;
		end
		o.digit_count = CNT_W'(count);
		o.pad_out = 8'(pad);
		o.zero_fill_out = zf;
		if (count == 0) begin
			o.has_digit = 1'b0;
			o.digit_char = 8'd0;
			o.is_last = 1'b1;
			digit_words_due.push_back(o);
		end
		for (int k = 0; k < count; k++) begin
			o.has_digit = 1'b1;
			o.digit_char = text[k];
			o.is_last = (k == count - 1);
			digit_words_due.push_back(o);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_digits(in_flight);
				values_sent <= values_sent + 1;
			end
			if (!in_valid || in_ready) begin
				if (values_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_value = values_to_send.pop_front();
					in_flight <= next_value;
					number <= next_value.number;
					action <= next_value.action;
					min_digits <= next_value.min_digits;
					width_total <= next_value.width_total;
					prefix_chars <= next_value.prefix_chars;
					pad_in <= next_value.pad_in;
					alternate_form <= next_value.alternate_form;
					zero_fill_in <= next_value.zero_fill_in;
					left_align <= next_value.left_align;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				words_checked <= words_checked + 1;
				if (digit_words_due.size() == 0) begin
					$display("%0t: unexpected digit word: has_digit %b char %h last %b",
						$time, has_digit, digit_char, is_last);
					mismatch_count <= mismatch_count + 1;
				end else begin
					due = digit_words_due.pop_front();
					if (has_digit !== due.has_digit ||
					    digit_char !== due.digit_char ||
					    is_last !== due.is_last ||
					    digit_count !== due.digit_count ||
					    pad_out !== due.pad_out ||
					    zero_fill_out !== due.zero_fill_out)
						mismatch_count <= mismatch_count + 1;
					if (has_digit !== due.has_digit)
						$display("%0t: has_digit expected %b got %b",
							$time, due.has_digit, has_digit);
					if (digit_char !== due.digit_char)
						$display("%0t: digit_char expected %h got %h",
							$time, due.digit_char, digit_char);
					if (is_last !== due.is_last)
						$display("%0t: is_last expected %b got %b",
							$time, due.is_last, is_last);
					if (digit_count !== due.digit_count)
						$display("%0t: digit_count expected %0d got %0d",
							$time, due.digit_count, digit_count);
					if (pad_out !== due.pad_out)
						$display("%0t: pad_out expected %0d got %0d",
							$time, due.pad_out, pad_out);
					if (zero_fill_out !== due.zero_fill_out)
						$display("%0t: zero_fill_out expected %b got %b",
							$time, due.zero_fill_out, zero_fill_out);
				end
			end
			if (hold_requests != hold_served) begin
				hold_served <= hold_requests;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic queue_value(input logic [63:0] num, input logic [2:0] act, input int prec,
			input int width, input int prefix, input int pad,
			input bit alt, input bit zf, input bit left);
		value_word_t w;
		w.number = num;
		w.action = act;
		w.min_digits = 9'(prec);
		w.width_total = 8'(width);
		w.prefix_chars = 2'(prefix);
		w.pad_in = 8'(pad);
		w.alternate_form = alt;
		w.zero_fill_in = zf;
		w.left_align = left;
		values_to_send.push_back(w);
	endtask

	task automatic queue_random(input int n);
		value_word_t w;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2: w.number = {$urandom, $urandom};
				3, 4: w.number = 64'($urandom_range(20));
				5: w.number = 64'd0;
				6: w.number = {1'b1, 31'($urandom), $urandom};
				7: w.number = ~64'd0 - 64'($urandom_range(20));
				8: w.number = 64'd1 << $urandom_range(63);
				default: w.number = {32'd0, $urandom};
			endcase
			w.action = 3'($urandom_range(ACT_RSV7));
			case ($urandom_range(9))
				0, 1, 2, 3, 4: w.min_digits = -9'sd1;
				5, 6: w.min_digits = 9'($urandom_range(25));
				7: w.min_digits = 9'sd0;
				8: w.min_digits = 9'($urandom_range(255));
				default: w.min_digits = 9'($urandom_range(511));
			endcase
			w.width_total = $urandom_range(1) ? 8'($urandom_range(255))
			                                  : 8'($urandom_range(30));
			w.prefix_chars = 2'($urandom_range(3));
			w.pad_in = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
			w.alternate_form = 1'($urandom_range(1));
			w.zero_fill_in = 1'($urandom_range(1));
			w.left_align = 1'($urandom_range(1));
			values_to_send.push_back(w);
		end
	endtask

	task automatic drain_phase();
		while (values_to_send.size() != 0 || in_valid || digit_words_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int start_count;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_value(64'd0, ACT_SDEC, 0, 0, 0, 0, 0, 0, 0);
		queue_value(64'd0, ACT_OCT, 0, 0, 0, 0, 1, 0, 0);
		queue_value(64'd0, ACT_LHEX, 0, 255, 0, 255, 1, 1, 0);
		queue_value(64'd0, ACT_UDEC, -1, 10, 1, 0, 0, 1, 0);
		queue_value(64'd0, ACT_OCT, -1, 0, 0, 0, 1, 0, 0);
		queue_value(~64'd0, ACT_SDEC, -1, 0, 0, 0, 0, 0, 0);
		queue_value(64'd1 << 63, ACT_SDEC, -1, 0, 0, 0, 0, 0, 0);
		queue_value(~64'd0 >> 1, ACT_SDEC, -1, 0, 0, 0, 0, 0, 0);
		queue_value(~64'd0, ACT_UDEC, -1, 0, 0, 0, 0, 0, 0);
		queue_value(~64'd0, ACT_OCT, -1, 0, 0, 0, 1, 0, 0);
		queue_value(~64'd0, ACT_OCT, 0, 0, 0, 0, 0, 0, 0);
		queue_value(~64'd0, ACT_LHEX, -1, 0, 0, 0, 0, 0, 0);
		queue_value(~64'd0, ACT_UHEX, -1, 0, 0, 0, 0, 0, 0);
		queue_value(64'h0123_4567_89AB_CDEF, ACT_LHEX, 20, 0, 0, 0, 0, 1, 0);
		queue_value(64'hFEDC_BA98_7654_3210, ACT_UHEX, -1, 40, 2, 3, 1, 1, 0);
		queue_value(64'd42, ACT_UDEC, 255, 0, 0, 0, 0, 1, 0);
		queue_value(64'd42, ACT_SDEC, -256, 255, 3, 0, 0, 1, 0);
		queue_value(64'd42, ACT_SDEC, -1, 255, 0, 17, 0, 1, 1);
		queue_value(64'd12345, ACT_UDEC, -1, 3, 2, 255, 0, 1, 0);
		queue_value(~64'd0, ACT_RSV5, -1, 0, 0, 0, 0, 0, 0);
		queue_value(64'd1 << 63, ACT_RSV6, 3, 0, 0, 0, 1, 1, 0);
		queue_value(64'd0, ACT_RSV7, 0, 0, 0, 0, 1, 0, 0);
		queue_value(64'd8, ACT_OCT, 2, 0, 0, 0, 1, 0, 0);
		queue_value(64'd0, ACT_OCT, 5, 0, 0, 0, 1, 1, 0);
		drain_phase();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 48; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 48; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			queue_random(RANDOM_PER_PHASE);
			if (phase == 2) begin
				start_count = values_sent;
				while (values_sent < start_count + 3)
					@(negedge clk);
				hold_requests = hold_requests + 1;
			end
			drain_phase();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d values and %0d digit words: extremes, all kinds, padding rules,",
			values_sent, words_checked);
		$display("sender gaps, receiver stalls, mixed idling and one long output hold-off");
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
